// ===== sv/ptt_pkg.sv =====
`timescale 1ns / 1ps

package ptt_pkg;

    // request kinds carried on s_tuser
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam int ID_W     = 8;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 24;
    localparam int DELAY_W  = 24;
    localparam int EXTRA_W  = 25;

    // one row of the task table
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   start;
        logic [PERIOD_W-1:0] period;
        logic [EXTRA_W-1:0]  extra;
    } entry_t;

endpackage

// ===== sv/periodic_task_timer_table.sv =====
`timescale 1ns / 1ps
// add and delete search the table row by row (read, then compare), then append, update or move a row
// tick: every table row is read and tested; each fired one-shot is moved out; output stalls hold the scan
// a new request is taken only while the sequencer idles; the table has one read port
// reset (rst_n low, asynchronous): task count and millisecond clock go to zero,
// sequencer idles, output and pending result are dropped; table rows are not cleared
module periodic_task_timer_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // task_id [7:0], period_ms [31:8], delay_ms [55:32]
    input  logic [1:0]  s_tuser,   // op [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // fired_task [7:0]
    output logic        m_tlast    // last_fired
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    // sequencer states: search for add/delete, scan for tick, move to fill a freed slot
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_EV,
        ST_MV_RD,
        ST_MV_WR,
        ST_SCAN_RD,
        ST_SCAN_EV
    } state_t;

    state_t state_reg, state_next;

    // latched request
    logic [1:0]                    op_reg, op_next;
    logic [ptt_pkg::ID_W-1:0]      id_reg, id_next;
    logic [ptt_pkg::PERIOD_W-1:0]  period_reg, period_next;
    logic [ptt_pkg::DELAY_W-1:0]   delay_reg, delay_next;

    // table control and clock
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [ptt_pkg::TIME_W-1:0]    now_reg, now_next;

    // a fired id is held back until the next one (or scan end) tells its last flag
    logic                          pend_valid_reg, pend_valid_next;
    logic [ptt_pkg::ID_W-1:0]      pend_id_reg, pend_id_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [ptt_pkg::ID_W-1:0]      out_task_reg, out_task_next;
    logic                          out_last_reg, out_last_next;

    // table memory, one write and one registered read per cycle
    ptt_pkg::entry_t               mem [TABLE_DEPTH];
    ptt_pkg::entry_t               rd_data_reg;
    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    ptt_pkg::entry_t               wr_data;

    // due-test unit for the tick scan
    logic [ptt_pkg::TIME_W-1:0]    elapsed;
    logic signed [33:0]            need;
    logic                          due;

    logic [CNT_W-1:0]              last_idx;
    logic                          out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_task_reg;
    assign m_tlast  = out_last_reg;

    assign last_idx = cnt_reg - CNT_ONE;
    assign out_free = !out_valid_reg || m_tready;

    // elapsed time against period plus signed extra delay
    assign elapsed = now_reg - rd_data_reg.start;
    assign need    = $signed({10'd0, rd_data_reg.period})
                   + $signed({{9{rd_data_reg.extra[ptt_pkg::EXTRA_W-1]}}, rd_data_reg.extra});
    assign due     = $signed({2'b00, elapsed}) >= need;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        period_next     = period_reg;
        delay_next      = delay_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_task_next   = out_task_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        wr_data         = rd_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tuser;
                    id_next     = s_tdata[7:0];
                    period_next = s_tdata[31:8];
                    delay_next  = s_tdata[55:32];
                    idx_next    = '0;
                    unique case (s_tuser)
                        ptt_pkg::OP_ADD, ptt_pkg::OP_DEL:
                        begin
                            state_next = ST_SRCH_RD;
                        end
                        ptt_pkg::OP_TICK:
                        begin
                            now_next   = now_reg + 32'd1;
                            state_next = ST_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SRCH_RD:
            begin
                if (idx_reg < cnt_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_SRCH_EV;
                end
                else
                begin
                    // id not in the table: append on add if there is room
                    if (op_reg == ptt_pkg::OP_ADD && cnt_reg < DEPTH_CNT)
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = cnt_reg[IDX_W-1:0];
                        wr_data.id     = id_reg;
                        wr_data.start  = now_reg;
                        wr_data.period = period_reg;
                        wr_data.extra  = {1'b0, delay_reg};
                        cnt_next       = cnt_reg + CNT_ONE;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SRCH_EV:
            begin
                if (rd_data_reg.id == id_reg)
                begin
                    if (op_reg == ptt_pkg::OP_ADD)
                    begin
                        // update: first firing comes delay ticks from now
                        wr_en          = 1'b1;
                        wr_data.start  = now_reg;
                        wr_data.period = period_reg;
                        wr_data.extra  = {1'b0, delay_reg} - {1'b0, period_reg};
                        state_next     = ST_IDLE;
                    end
                    else if (idx_reg == last_idx)
                    begin
                        cnt_next   = last_idx;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_MV_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CNT_ONE;
                    state_next = ST_SRCH_RD;
                end
            end

            ST_MV_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = last_idx[IDX_W-1:0];
                state_next = ST_MV_WR;
            end

            ST_MV_WR:
            begin
                // last row fills the freed slot; in a scan that slot is examined again
                wr_en      = 1'b1;
                cnt_next   = last_idx;
                state_next = (op_reg == ptt_pkg::OP_DEL) ? ST_IDLE : ST_SCAN_RD;
            end

            ST_SCAN_RD:
            begin
                if (idx_reg < cnt_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_SCAN_EV;
                end
                else if (pend_valid_reg)
                begin
                    // end of scan: held id is the last one of this tick
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_task_next   = pend_id_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN_EV:
            begin
                if (!due)
                begin
                    idx_next   = idx_reg + CNT_ONE;
                    state_next = ST_SCAN_RD;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_task_next  = pend_id_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = rd_data_reg.id;
                    if (rd_data_reg.period == '0)
                    begin
                        // one-shot: remove
                        if (idx_reg == last_idx)
                        begin
                            cnt_next   = last_idx;
                            state_next = ST_SCAN_RD;
                        end
                        else
                        begin
                            state_next = ST_MV_RD;
                        end
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_data.start = now_reg;
                        wr_data.extra = '0;
                        idx_next      = idx_reg + CNT_ONE;
                        state_next    = ST_SCAN_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= '0;
            id_reg         <= '0;
            period_reg     <= '0;
            delay_reg      <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            now_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_id_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_task_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            id_reg         <= id_next;
            period_reg     <= period_next;
            delay_reg      <= delay_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            now_reg        <= now_next;
            pend_valid_reg <= pend_valid_next;
            pend_id_reg    <= pend_id_next;
            out_valid_reg  <= out_valid_next;
            out_task_reg   <= out_task_next;
            out_last_reg   <= out_last_next;
        end
    end

    // table storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

`ifndef ASSERT_OFF
    // task count never passes the table size
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_CNT)
        else $error("task count beyond table depth");

    // a held-back id exists only while a tick is being worked
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_SCAN_RD || state_reg == ST_SCAN_EV ||
                            state_reg == ST_MV_RD || state_reg == ST_MV_WR))
        else $error("pending id outside a scan");

    // the millisecond clock moves only on an accepted tick
    a_now_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready && s_tuser == ptt_pkg::OP_TICK) |=> $stable(now_reg))
        else $error("clock moved without a tick");

    // add and delete raise no result
    a_no_out_add_del: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser != ptt_pkg::OP_TICK && !out_valid_reg)
        |=> !out_valid_reg)
        else $error("result raised by add or delete");
`endif

endmodule
